// File: src/tsfm_pkg.sv
`timescale 1ns / 1ps

package tsfm_pkg;

    localparam int MAX_TRACKS       = 64;
    localparam int MAX_SECTORS      = 32;
    localparam int TRK_W            = $clog2(MAX_TRACKS);
    localparam int SEC_W            = 5;
    localparam int WORD_W           = MAX_SECTORS;
    localparam int NT_W             = 7;
    localparam int NS_W             = 6;
    localparam int GRP_W            = 11;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 7;

    localparam logic [TRK_W-1:0] FIRST_DATA_TRACK = TRK_W'(3);
    localparam logic [TRK_W-1:0] LAST_TRACK       = TRK_W'(MAX_TRACKS - 1);

    localparam logic [2:0] OP_MARK_USED  = 3'd0;
    localparam logic [2:0] OP_MARK_FREE  = 3'd1;
    localparam logic [2:0] OP_QUERY      = 3'd2;
    localparam logic [2:0] OP_FIND_FIRST = 3'd3;
    localparam logic [2:0] OP_FIND_NEXT  = 3'd4;
    localparam logic [2:0] OP_FORMAT     = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TRACKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTORS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR     = 2'd2;

    localparam logic [NT_W-1:0] RST_TRACKS  = 7'd35;
    localparam logic [NS_W-1:0] RST_SECTORS = 6'd16;
    localparam logic [5:0]      RST_DIR     = 6'd17;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [TRK_W-1:0] track;
        logic [SEC_W-1:0] sector;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic             is_free;
        logic [5:0]       found_track;
        logic [SEC_W-1:0] found_sector;
        logic [GRP_W-1:0] found_group;
    } t_out_item;

    typedef struct packed {
        logic [NT_W-1:0]  tracks_in_use;
        logic [NS_W-1:0]  track_sectors;
        logic [TRK_W-1:0] directory_track;
    } t_cfg;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [TRK_W-1:0]  addr;
        logic [WORD_W-1:0] wdata;
    } t_mem_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MODIFY,
        S_SCAN,
        S_FORMAT,
        S_DONE
    } t_state;

    function automatic logic [NT_W-1:0] eff_tracks(input logic [NT_W-1:0] n);
        return (n > NT_W'(MAX_TRACKS)) ? NT_W'(MAX_TRACKS) : n;
    endfunction

    function automatic logic [NS_W-1:0] eff_sectors(input logic [NS_W-1:0] n);
        return (n > NS_W'(MAX_SECTORS)) ? NS_W'(MAX_SECTORS) : n;
    endfunction

    function automatic logic [WORD_W-1:0] sector_mask(input logic [NS_W-1:0] es);
        logic [WORD_W-1:0] m;
        for (int i = 0; i < WORD_W; i++) begin
            m[i] = (NS_W'(i) < es);
        end
        return m;
    endfunction

    // highest set bit
    function automatic logic [SEC_W-1:0] top_bit(input logic [WORD_W-1:0] w);
        logic [SEC_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (w[i]) begin
                idx = SEC_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: src/tsfm_map_mem.sv
`timescale 1ns / 1ps

module tsfm_map_mem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tsfm_pkg::t_mem_req          i_req,
    output logic [tsfm_pkg::WORD_W-1:0] o_rd_data
);
    import tsfm_pkg::*;

    logic [WORD_W-1:0]     r_mem [MAX_TRACKS];
    logic [MAX_TRACKS-1:0] r_vld;
    logic [MAX_TRACKS-1:0] n_vld;
    logic [WORD_W-1:0]     r_rd_data;
    logic                  r_rd_vld;

    always_comb begin
        n_vld = r_vld;
        if (i_req.wr_en) begin
            n_vld[i_req.addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr];
            r_rd_vld  <= r_vld[i_req.addr];
        end
    end

    // unwritten entries read as used
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// File: src/tsfm_ctrl.sv
`timescale 1ns / 1ps

module tsfm_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tsfm_pkg::t_cfg              i_cfg,
    input  logic                        i_in_valid,
    input  tsfm_pkg::t_in_item          i_in_data,
    output logic                        o_in_stall,
    output logic                        o_res_valid,
    output tsfm_pkg::t_out_item         o_res,
    input  logic                        i_res_ready,
    output tsfm_pkg::t_mem_req          o_mem_req,
    input  logic [tsfm_pkg::WORD_W-1:0] i_rd_data
);
    import tsfm_pkg::*;

    t_state            r_state, n_state;
    logic [2:0]        r_op, n_op;
    logic [TRK_W-1:0]  r_trk, n_trk;
    logic [SEC_W-1:0]  r_sec, n_sec;
    logic [1:0]        r_status, n_status;
    logic              r_is_free, n_is_free;
    logic [TRK_W-1:0]  r_addr, n_addr;
    logic [TRK_W-1:0]  r_end, n_end;
    logic              r_issue, n_issue;
    logic              r_down, n_down;
    logic              r_ev, n_ev;
    logic [TRK_W-1:0]  r_ev_trk, n_ev_trk;
    logic              r_ev_last, n_ev_last;
    logic              r_found, n_found;
    logic [TRK_W-1:0]  r_best_trk, n_best_trk;
    logic [SEC_W-1:0]  r_best_sec, n_best_sec;

    logic [NT_W-1:0]   nt;
    logic [NS_W-1:0]   es;
    logic [WORD_W-1:0] mask;
    logic [TRK_W-1:0]  dir;
    logic              accept;
    logic              in_range_err;
    logic              in_trk_err;
    logic              ff_up_ok;
    logic              ff_dn_ok;
    logic              dn_ok;
    logic [TRK_W-1:0]  dn_start;
    logic [WORD_W-1:0] ev_word;
    logic [SEC_W-1:0]  ev_sec;
    logic              ev_hit;
    logic              ev_better;
    logic              pass_end;
    logic              is_search;
    logic [WORD_W-1:0] bit_sel;
    logic [11:0]       grp_full;

    assign nt     = eff_tracks(i_cfg.tracks_in_use);
    assign es     = eff_sectors(i_cfg.track_sectors);
    assign mask   = sector_mask(es);
    assign dir    = i_cfg.directory_track;
    assign accept = (r_state == S_IDLE) && i_in_valid;

    assign in_trk_err   = {1'b0, i_in_data.track} >= nt;
    assign in_range_err = in_trk_err || ({1'b0, i_in_data.sector} >= es);
    assign ff_up_ok     = ({1'b0, dir} + NT_W'(1)) < nt;
    assign ff_dn_ok     = dir > FIRST_DATA_TRACK;

    assign dn_ok    = (r_op == OP_FIND_FIRST) ? ff_dn_ok : (r_trk >= FIRST_DATA_TRACK);
    assign dn_start = (r_op == OP_FIND_FIRST) ? dir - TRK_W'(1) : r_trk;

    assign ev_word   = i_rd_data & mask;
    assign ev_sec    = top_bit(ev_word);
    assign ev_hit    = r_ev && (|ev_word) && !((r_op == OP_FIND_NEXT) && (r_ev_trk == dir));
    assign ev_better = ev_hit && (!r_found || (ev_sec > r_best_sec));
    assign pass_end  = r_ev && r_ev_last;
    assign is_search = (r_op == OP_FIND_FIRST) || (r_op == OP_FIND_NEXT);
    assign bit_sel   = WORD_W'(1) << r_sec;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in_data.opcode)
                        OP_MARK_USED, OP_MARK_FREE, OP_QUERY:
                            n_state = in_range_err ? S_DONE : S_MODIFY;
                        OP_FIND_FIRST:
                            n_state = (ff_up_ok || ff_dn_ok) ? S_SCAN : S_DONE;
                        OP_FIND_NEXT:
                            n_state = in_trk_err ? S_DONE : S_SCAN;
                        OP_FORMAT:
                            n_state = S_FORMAT;
                        default:
                            n_state = S_DONE;
                    endcase
                end
            end
            S_MODIFY: n_state = S_DONE;
            S_SCAN: begin
                if ((r_op == OP_FIND_NEXT) && ev_hit) begin
                    n_state = S_DONE;
                end else if (pass_end) begin
                    if (r_found || ev_better || r_down || !dn_ok) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FORMAT: begin
                if (r_addr == LAST_TRACK) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_mem_req       = '0;
        o_mem_req.addr  = r_addr;
        o_in_stall      = 1'b1;
        o_res_valid     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall      = 1'b0;
                o_mem_req.rd_en = i_in_valid;
                o_mem_req.addr  = i_in_data.track;
            end
            S_MODIFY: begin
                o_mem_req.addr  = r_trk;
                o_mem_req.wr_en = (r_op == OP_MARK_USED) || (r_op == OP_MARK_FREE);
                o_mem_req.wdata = (r_op == OP_MARK_FREE) ? (i_rd_data | bit_sel)
                                                         : (i_rd_data & ~bit_sel);
            end
            S_SCAN: begin
                o_mem_req.rd_en = r_issue;
            end
            S_FORMAT: begin
                o_mem_req.wr_en = 1'b1;
                o_mem_req.wdata = ((r_addr >= FIRST_DATA_TRACK) && ({1'b0, r_addr} < nt))
                                  ? mask : '0;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        n_op       = r_op;
        n_trk      = r_trk;
        n_sec      = r_sec;
        n_status   = r_status;
        n_is_free  = r_is_free;
        n_addr     = r_addr;
        n_end      = r_end;
        n_issue    = r_issue;
        n_down     = r_down;
        n_ev       = 1'b0;
        n_ev_trk   = r_ev_trk;
        n_ev_last  = r_ev_last;
        n_found    = r_found;
        n_best_trk = r_best_trk;
        n_best_sec = r_best_sec;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op      = i_in_data.opcode;
                    n_trk     = i_in_data.track;
                    n_sec     = i_in_data.sector;
                    n_is_free = 1'b0;
                    n_found   = 1'b0;
                    n_issue   = 1'b0;
                    n_down    = 1'b0;
                    n_status  = ST_OK;
                    n_addr    = '0;
                    unique case (i_in_data.opcode)
                        OP_MARK_USED, OP_MARK_FREE, OP_QUERY: begin
                            n_status = in_range_err ? ST_RANGE : ST_OK;
                        end
                        OP_FIND_FIRST: begin
                            if (ff_up_ok) begin
                                n_addr  = dir + TRK_W'(1);
                                n_end   = TRK_W'(nt - NT_W'(1));
                                n_issue = 1'b1;
                            end else if (ff_dn_ok) begin
                                n_addr  = dir - TRK_W'(1);
                                n_end   = FIRST_DATA_TRACK;
                                n_issue = 1'b1;
                                n_down  = 1'b1;
                            end
                        end
                        OP_FIND_NEXT: begin
                            if (in_trk_err) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_addr  = i_in_data.track;
                                n_end   = TRK_W'(nt - NT_W'(1));
                                n_issue = 1'b1;
                            end
                        end
                        OP_FORMAT: ;
                        default: n_status = ST_RANGE;
                    endcase
                end
            end
            S_MODIFY: begin
                n_is_free = (r_op == OP_QUERY) && i_rd_data[r_sec];
            end
            S_SCAN: begin
                if (r_issue) begin
                    if (r_addr == r_end) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_down ? r_addr - TRK_W'(1) : r_addr + TRK_W'(1);
                    end
                end
                n_ev      = r_issue;
                n_ev_trk  = r_addr;
                n_ev_last = (r_addr == r_end);
                if (ev_better) begin
                    n_found    = 1'b1;
                    n_best_trk = r_ev_trk;
                    n_best_sec = ev_sec;
                end
                if (pass_end && !r_found && !ev_better && !r_down && dn_ok) begin
                    n_addr  = dn_start;
                    n_end   = FIRST_DATA_TRACK;
                    n_issue = 1'b1;
                    n_down  = 1'b1;
                    n_ev    = 1'b0;
                end
            end
            S_FORMAT: begin
                n_addr = r_addr + TRK_W'(1);
            end
            S_DONE: ;
            default: ;
        endcase
    end

    assign grp_full = r_best_trk * es;

    always_comb begin
        o_res              = '0;
        o_res.status       = (is_search && (r_status == ST_OK) && !r_found) ? ST_NONE
                                                                            : r_status;
        o_res.is_free      = r_is_free;
        if (is_search && r_found) begin
            o_res.found_track  = r_best_trk;
            o_res.found_sector = r_best_sec;
            o_res.found_group  = GRP_W'(grp_full) + GRP_W'(r_best_sec);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_issue <= 1'b0;
            r_ev    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_issue <= n_issue;
            r_ev    <= n_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_trk      <= n_trk;
        r_sec      <= n_sec;
        r_status   <= n_status;
        r_is_free  <= n_is_free;
        r_addr     <= n_addr;
        r_end      <= n_end;
        r_down     <= n_down;
        r_ev_trk   <= n_ev_trk;
        r_ev_last  <= n_ev_last;
        r_found    <= n_found;
        r_best_trk <= n_best_trk;
        r_best_sec <= n_best_sec;
    end

`ifndef ASSERT_OFF
    a_write_only_rmw_or_format: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.wr_en |-> (r_state == S_MODIFY || r_state == S_FORMAT))
        else $error("map write outside modify or format");

    a_next_skips_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_op == OP_FIND_NEXT && o_res.status == ST_OK)
        |-> (o_res.found_track != dir))
        else $error("find next returned the directory track");

    a_found_sector_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_found && is_search) |-> ({1'b0, o_res.found_sector} < es))
        else $error("found sector beyond sector count");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> (o_res_valid && $stable(o_res)))
        else $error("pending result changed");
`endif

endmodule

// File: src/track_sector_free_map_allocator.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Beat
// in        input      i_in_valid / o_in_stall    t_in_item  (opcode, track, sector)
// out       output     o_out_valid / i_out_stall  t_out_item (status, is_free, found_*)
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item at a time. Mark and query: track word read at accept, written in S_MODIFY
// (mark only), result loaded from S_DONE. Find first / find next: one track word
// read per cycle from the map RAM, then the result register is loaded from S_DONE.
// Format: all 64 track words written, then the result loads; next accept from S_IDLE.
// Sync active-low reset; map reads as all used after reset (per-track valid bits).
// A stalled result is held; the next item may be accepted and runs until its
// own result is ready.

module track_sector_free_map_allocator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  tsfm_pkg::t_in_item                  i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output tsfm_pkg::t_out_item                 o_out_data,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tsfm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tsfm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tsfm_pkg::*;

    t_cfg              r_cfg, n_cfg;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;
    logic              res_valid;
    logic              res_ready;
    t_out_item         res;
    t_mem_req          mem_req;
    logic [WORD_W-1:0] rd_data;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TRACKS:  n_cfg.tracks_in_use   = i_cfg_data;
                CFG_SECTORS: n_cfg.track_sectors   = i_cfg_data[NS_W-1:0];
                CFG_DIR:     n_cfg.directory_track = i_cfg_data[TRK_W-1:0];
                default: ;
            endcase
        end
    end

    assign res_ready = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (res_ready) begin
            n_out_valid = res_valid;
            if (res_valid) begin
                n_out = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '{tracks_in_use:   RST_TRACKS,
                             track_sectors:   RST_SECTORS,
                             directory_track: RST_DIR};
            r_out_valid <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    tsfm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_mem_req   (mem_req),
        .i_rd_data   (rd_data)
    );

    tsfm_map_mem u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

endmodule
